### sv/ots_pkg.sv
`default_nettype none

package ots_pkg;

  // Table geometry
  localparam int unsigned SLOTS      = 64;
  localparam int unsigned OWNER_BITS = 16;
  localparam int unsigned SLOT_BITS  = $clog2(SLOTS);
  localparam int unsigned CNT_BITS   = $clog2(SLOTS + 1);

  // Capacity register reset value
  localparam logic [6:0] CAP_RESET = 7'd64;

  typedef logic [OWNER_BITS-1:0] owner_t;
  typedef logic [SLOT_BITS-1:0]  slot_idx_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  typedef enum logic [2:0] {
    MODE_CREATE  = 3'd0,
    MODE_DELETE  = 3'd1,
    MODE_RESERVE = 3'd2,
    MODE_RELEASE = 3'd3,
    MODE_QUERY   = 3'd4,
    MODE_CANCEL  = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_TABLE  = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_BAD_SLOT  = 3'd3,
    ST_FREE      = 3'd4,
    ST_BAD_OWNER = 3'd5,
    ST_FULL      = 3'd6,
    ST_NOT_FOUND = 3'd7
  } status_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  slot;
    logic [15:0] owner_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] value;
    logic [6:0]  free_count;
    logic [6:0]  used_count;
  } out_item_t;

endpackage

`default_nettype wire

### sv/owner_tagged_slot_table.sv
// Owner-tagged slot allocator. One command transaction in (mode, slot,
// owner_id), one result transaction out (status, value, free_count,
// used_count). Both channels use valid/stall; the capacity register is
// written over a separate valid/ready channel (always ready) and is only
// sampled by create.
//
// States from input accept to result valid, by mode: create, delete,
// unused modes, any error decided up front: EXEC, DONE; release, query:
// EXEC, WAIT, DONE; reserve, cancel: EXEC, SCAN, DONE. The scan covers up
// to the held capacity, one slot read per cycle, pipelined against the
// compare; reserve stops at the first free slot.
// One command is processed at a time; the input stays stalled until the
// engine is back in idle. The owner RAM read port sets the scan rate. A new
// command is taken while the previous result still sits in the output
// register; if the receiver stalls, the finished result waits in the engine
// and the input stays stalled until it drains.
//
// Reset: no table, counts zero, capacity register = 64. Per-slot valid bits
// mark written slots, so create frees the table by clearing them and no
// clearing pass over the RAM is needed.

`default_nettype none

module owner_tagged_slot_table (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // command channel
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire ots_pkg::in_item_t in_item_i,
  // result channel
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      ots_pkg::out_item_t out_item_o,
  // capacity register write
  input  wire logic              cfg_valid_i,
  output      logic              cfg_ready_o,
  input  wire logic [6:0]        cfg_data_i
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_WAIT = 5'b00100,
    S_SCAN = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // control state
  logic                     present_q, present_d;
  ots_pkg::cnt_t            held_q, held_d;
  ots_pkg::cnt_t            free_q, free_d;
  logic [ots_pkg::SLOTS-1:0] used_q, used_d;   // slot holds a written owner
  logic [6:0]               cap_q;
  ots_pkg::cnt_t            idx_q, idx_d;      // next slot to read
  logic                     pend_q, pend_d;    // read in flight
  logic                     found_q, found_d;
  logic                     out_valid_q, out_valid_d;

  // payload
  logic [2:0]               mode_q;
  logic [7:0]               slot_q;
  ots_pkg::owner_t          owner_q;
  ots_pkg::slot_idx_t       chk_q, chk_d;      // slot whose data returns
  logic [2:0]               res_status_q, res_status_d;
  logic [15:0]              res_value_q, res_value_d;
  ots_pkg::out_item_t       out_q, out_d;

  // RAM port
  logic                     mem_we, mem_re;
  ots_pkg::slot_idx_t       mem_waddr, mem_raddr;
  ots_pkg::owner_t          mem_wdata, mem_rdata, owner_rd;

  logic                     accept;
  logic                     out_free;
  ots_pkg::cnt_t            cap_clamped;

  ots_ram #(
    .WIDTH(ots_pkg::OWNER_BITS),
    .DEPTH(ots_pkg::SLOTS)
  ) u_owner_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Free slots read as owner 0 regardless of stale RAM contents
  assign owner_rd = used_q[chk_q] ? mem_rdata : '0;

  always_comb begin
    if (cap_q == 7'd0) begin
      cap_clamped = ots_pkg::cnt_t'(1);
    end else if (32'(cap_q) > ots_pkg::SLOTS) begin
      cap_clamped = ots_pkg::cnt_t'(ots_pkg::SLOTS);
    end else begin
      cap_clamped = ots_pkg::cnt_t'(cap_q);
    end
  end

  always_comb begin
    state_d      = state_q;
    present_d    = present_q;
    held_d       = held_q;
    free_d       = free_q;
    used_d       = used_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    found_d      = found_q;
    chk_d        = chk_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    mem_we       = 1'b0;
    mem_waddr    = chk_q;
    mem_wdata    = owner_q;
    mem_re       = 1'b0;
    mem_raddr    = idx_q[ots_pkg::SLOT_BITS-1:0];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_status_d = ots_pkg::ST_OK;
        res_value_d  = '0;
        state_d      = S_DONE;
        idx_d        = '0;
        pend_d       = 1'b0;
        found_d      = 1'b0;
        if (mode_q == ots_pkg::MODE_CREATE) begin
          if (present_q) begin
            res_status_d = ots_pkg::ST_EXISTS;
          end else begin
            held_d      = cap_clamped;
            free_d      = cap_clamped;
            present_d   = 1'b1;
            used_d      = '0;
            res_value_d = 16'(cap_clamped);
          end
        end else if (mode_q > ots_pkg::MODE_CANCEL) begin
          // unused modes: plain ok, no state change
        end else if (!present_q) begin
          res_status_d = ots_pkg::ST_NO_TABLE;
        end else begin
          unique case (mode_q)
            ots_pkg::MODE_DELETE: begin
              present_d = 1'b0;
            end
            ots_pkg::MODE_RESERVE: begin
              if (owner_q == '0) begin
                res_status_d = ots_pkg::ST_BAD_OWNER;
              end else begin
                state_d = S_SCAN;
              end
            end
            ots_pkg::MODE_RELEASE, ots_pkg::MODE_QUERY: begin
              if (32'(slot_q) >= 32'(held_q)) begin
                res_status_d = ots_pkg::ST_BAD_SLOT;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = ots_pkg::slot_idx_t'(slot_q);
                chk_d     = ots_pkg::slot_idx_t'(slot_q);
                state_d   = S_WAIT;
              end
            end
            ots_pkg::MODE_CANCEL: begin
              state_d = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      S_WAIT: begin
        state_d = S_DONE;
        if (mode_q == ots_pkg::MODE_QUERY) begin
          res_value_d = 16'(owner_rd);
        end else if (owner_rd == '0) begin
          res_status_d = ots_pkg::ST_FREE;
        end else begin
          res_value_d   = 16'(owner_rd);
          used_d[chk_q] = 1'b0;
          free_d        = free_q + ots_pkg::cnt_t'(1);
        end
      end

      S_SCAN: begin
        // Compare the slot read last cycle while reading the next one
        if (mode_q == ots_pkg::MODE_RESERVE && pend_q && owner_rd == '0) begin
          mem_we        = 1'b1;
          used_d[chk_q] = 1'b1;
          free_d        = free_q - ots_pkg::cnt_t'(1);
          res_value_d   = 16'(chk_q);
          pend_d        = 1'b0;
          state_d       = S_DONE;
        end else begin
          if (mode_q == ots_pkg::MODE_CANCEL && pend_q && owner_rd == owner_q) begin
            found_d = 1'b1;
            if (owner_q != '0) begin
              used_d[chk_q] = 1'b0;
              free_d        = free_q + ots_pkg::cnt_t'(1);
            end
          end
          if (idx_q < held_q) begin
            mem_re = 1'b1;
            chk_d  = idx_q[ots_pkg::SLOT_BITS-1:0];
            idx_d  = idx_q + ots_pkg::cnt_t'(1);
            pend_d = 1'b1;
          end else begin
            pend_d = 1'b0;
          end
          if (!pend_q && idx_q >= held_q) begin
            state_d = S_DONE;
            if (mode_q == ots_pkg::MODE_RESERVE) begin
              res_status_d = ots_pkg::ST_FULL;
            end else if (!found_q) begin
              res_status_d = ots_pkg::ST_NOT_FOUND;
            end
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.status      = res_status_q;
          out_d.value       = res_value_q;
          out_d.free_count  = present_q ? 7'(free_q) : 7'd0;
          out_d.used_count  = present_q ? 7'(held_q - free_q) : 7'd0;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      present_q   <= 1'b0;
      held_q      <= '0;
      free_q      <= '0;
      used_q      <= '0;
      cap_q       <= ots_pkg::CAP_RESET;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      present_q   <= present_d;
      held_q      <= held_d;
      free_q      <= free_d;
      used_q      <= used_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= in_item_i.mode;
      slot_q  <= in_item_i.slot;
      owner_q <= ots_pkg::owner_t'(in_item_i.owner_id);
    end
    chk_q        <= chk_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    out_q        <= out_d;
  end

  // Checks
  a_free_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= held_q)
    else $error("free count exceeds held capacity");

  a_write_only_reserve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_SCAN) && (mode_q == ots_pkg::MODE_RESERVE))
    else $error("owner RAM written outside a reserve scan");

  a_pending_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && pend_q) |-> (32'(chk_q) < 32'(held_q)))
    else $error("scan compares a slot beyond held capacity");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside the done state");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |=> (state_q != S_EXEC))
    else $error("new command started during a scan");

endmodule

`default_nettype wire

### sv/ots_ram.sv
`default_nettype none

module ots_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### test/testbench.sv
`default_nettype none

module testbench;

  // Mode codes the block does not define; they must leave the table alone.
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;

  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles; well above a full scan
  localparam int DRAIN_CYCLES   = 8;
  localparam int TAIL_CYCLES    = 100;
  localparam int PHASE_ITEMS    = 100;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_style_e;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  ots_pkg::in_item_t  in_item_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  ots_pkg::out_item_t out_item_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [6:0]         cfg_data_i  = '0;

  owner_tagged_slot_table dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow copy of the slot table. Updated once per accepted command
  // transaction, in acceptance order, so it always mirrors the block.
  // ---------------------------------------------------------------------------
  ots_pkg::owner_t slot_owner_q [ots_pkg::SLOTS];
  int              free_slots_q   = 0;
  int              held_cap_q     = 0;
  bit              table_live_q   = 1'b0;
  logic [6:0]      capacity_reg_q = ots_pkg::CAP_RESET;  // sampled only by create

  task automatic table_apply(input ots_pkg::in_item_t cmd, output ots_pkg::out_item_t res);
    logic [2:0]  st;
    logic [15:0] val;
    int          cap;
    bit          found;
    st  = ots_pkg::ST_OK;
    val = '0;
    if (cmd.mode == ots_pkg::MODE_CREATE) begin
      if (table_live_q) begin
        st = ots_pkg::ST_EXISTS;
      end else begin
        // out-of-range capacity is clamped to 1..SLOTS at create time
        cap = capacity_reg_q;
        if (cap == 0) cap = 1;
        if (cap > ots_pkg::SLOTS) cap = ots_pkg::SLOTS;
        held_cap_q = cap;
        for (int i = 0; i < cap; i++) slot_owner_q[i] = '0;
        free_slots_q = cap;
        table_live_q = 1'b1;
        val = 16'(cap);
      end
    end else if (cmd.mode == MODE_SPARE_6 || cmd.mode == MODE_SPARE_7) begin
      // spare codes: plain ok, no state change, table or not
    end else if (!table_live_q) begin
      st = ots_pkg::ST_NO_TABLE;
    end else begin
      case (cmd.mode)
        ots_pkg::MODE_DELETE: begin
          table_live_q = 1'b0;
        end
        ots_pkg::MODE_RESERVE: begin
          if (cmd.owner_id == '0) begin
            st = ots_pkg::ST_BAD_OWNER;
          end else begin
            st = ots_pkg::ST_FULL;
            for (int i = 0; i < held_cap_q; i++) begin
              if (slot_owner_q[i] == '0) begin
                slot_owner_q[i] = cmd.owner_id;
                free_slots_q--;
                val = 16'(i);
                st  = ots_pkg::ST_OK;
                break;
              end
            end
          end
        end
        ots_pkg::MODE_RELEASE, ots_pkg::MODE_QUERY: begin
          if (cmd.slot >= held_cap_q) begin
            st = ots_pkg::ST_BAD_SLOT;
          end else if (cmd.mode == ots_pkg::MODE_QUERY) begin
            val = slot_owner_q[cmd.slot];
          end else if (slot_owner_q[cmd.slot] == '0) begin
            st = ots_pkg::ST_FREE;
          end else begin
            val = slot_owner_q[cmd.slot];
            slot_owner_q[cmd.slot] = '0;
            free_slots_q++;
          end
        end
        default: begin  // cancel
          // owner 0 matches free slots: reports whether any is free, frees nothing
          found = 1'b0;
          for (int i = 0; i < held_cap_q; i++) begin
            if (slot_owner_q[i] == cmd.owner_id) begin
              found = 1'b1;
              if (cmd.owner_id != '0) begin
                slot_owner_q[i] = '0;
                free_slots_q++;
              end
            end
          end
          if (!found) st = ots_pkg::ST_NOT_FOUND;
        end
      endcase
    end
    res.status     = st;
    res.value      = val;
    res.free_count = table_live_q ? 7'(free_slots_q) : 7'd0;
    res.used_count = table_live_q ? 7'(held_cap_q - free_slots_q) : 7'd0;
  endtask

  // ---------------------------------------------------------------------------
  // Queues shared by driver, monitor and sequencer.
  // ---------------------------------------------------------------------------
  ots_pkg::in_item_t  pending_cmds [$];
  ots_pkg::out_item_t expected_results [$];
  ots_pkg::out_item_t next_result;
  ots_pkg::out_item_t oldest_result;
  int                 mismatches = 0;

  // sender burst shaping and receiver stall pattern, chosen per phase
  bit           sender_bursty = 1'b0;
  int           burst_left    = 0;
  int           gap_left      = 0;
  stall_style_e stall_style   = STALL_NONE;
  int           stall_run     = 0;
  bit           stall_level   = 1'b0;

  // ---------------------------------------------------------------------------
  // Driver: predicts on every accepted command transaction, then puts up the
  // next pending command unless a gap is running. A stalled command is held.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_item_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        table_apply(in_item_i, next_result);
        expected_results.push_back(next_result);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          in_item_i  <= pending_cmds.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else if (sender_bursty) begin
            burst_left = $urandom_range(0, 15);
            gap_left   = $urandom_range(1, 10);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transaction against the oldest prediction,
  // field by field, and drives the stall pattern of the receiver.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing predicted: %h", out_item_o);
          mismatches++;
        end else begin
          oldest_result = expected_results.pop_front();
          if (out_item_o.status !== oldest_result.status) begin
            $error("status: expected %0d, actual %0d",
                   oldest_result.status, out_item_o.status);
            mismatches++;
          end
          if (out_item_o.value !== oldest_result.value) begin
            $error("value: expected %0d, actual %0d",
                   oldest_result.value, out_item_o.value);
            mismatches++;
          end
          if (out_item_o.free_count !== oldest_result.free_count) begin
            $error("free_count: expected %0d, actual %0d",
                   oldest_result.free_count, out_item_o.free_count);
            mismatches++;
          end
          if (out_item_o.used_count !== oldest_result.used_count) begin
            $error("used_count: expected %0d, actual %0d",
                   oldest_result.used_count, out_item_o.used_count);
            mismatches++;
          end
        end
      end
      case (stall_style)
        STALL_NONE:   out_stall_i <= 1'b0;
        STALL_RANDOM: out_stall_i <= ($urandom_range(0, 3) == 0);
        default: begin
          // alternating runs of stall and flow, random lengths
          if (stall_run == 0) begin
            stall_run   = $urandom_range(1, 12);
            stall_level = ~stall_level;
          end
          stall_run--;
          out_stall_i <= stall_level;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any accepted transaction on any channel restarts the count.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer helpers
  // ---------------------------------------------------------------------------
  function automatic ots_pkg::in_item_t pack_cmd(input logic [2:0] mode,
                                                 input logic [7:0] slot,
                                                 input logic [15:0] owner);
    ots_pkg::in_item_t c;
    c.mode     = mode;
    c.slot     = slot;
    c.owner_id = owner;
    return c;
  endfunction

  // Mostly well-formed traffic: a small owner pool so cancels hit, slots
  // mostly inside the table, occasional full-range noise on slot and owner.
  function automatic ots_pkg::in_item_t random_cmd(input int eff_cap, input int reserve_pct);
    ots_pkg::in_item_t c;
    int                r;
    r = $urandom_range(0, 99);
    c.slot = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, eff_cap))
                                         : 8'($urandom_range(0, 255));
    if ($urandom_range(0, 19) == 0)      c.owner_id = '0;
    else if ($urandom_range(0, 7) == 0)  c.owner_id = 16'($urandom_range(0, 16'hFFFF));
    else                                 c.owner_id = 16'($urandom_range(1, 6));
    if (r < reserve_pct)              c.mode = ots_pkg::MODE_RESERVE;
    else if (r < reserve_pct + 22)    c.mode = ots_pkg::MODE_RELEASE;
    else if (r < reserve_pct + 34)    c.mode = ots_pkg::MODE_QUERY;
    else if (r < reserve_pct + 44)    c.mode = ots_pkg::MODE_CANCEL;
    else if (r < reserve_pct + 47)    c.mode = ots_pkg::MODE_CREATE;
    else if (r < reserve_pct + 49)    c.mode = ots_pkg::MODE_DELETE;
    else if (r < reserve_pct + 50)    c.mode = MODE_SPARE_6;
    else if (r < reserve_pct + 51)    c.mode = MODE_SPARE_7;
    else                              c.mode = ots_pkg::MODE_RELEASE;
    return c;
  endfunction

  // Everything sent, accepted and answered; then DRAIN_CYCLES of margin.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [6:0] cap);
    cfg_data_i  <= cap;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    capacity_reg_q = cap;
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer: a directed phase, then random phases, each at its own
  // capacity and idling style. Capacity is only written with the block idle;
  // each phase drains fully first, which also makes the sender hold off.
  // ---------------------------------------------------------------------------
  initial begin
    int                phase_caps [10];
    int                eff_cap;
    int                reserve_pct;
    logic [6:0]        cap_setting;
    ots_pkg::in_item_t c;

    for (int i = 0; i < ots_pkg::SLOTS; i++) slot_owner_q[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed phase, three-slot table
    sender_bursty = 1'b1;
    stall_style   = STALL_RANDOM;
    write_capacity(7'd3);
    pending_cmds.push_back(pack_cmd(ots_pkg::MODE_RESERVE, 8'd0, 16'd1));   // no table
    pending_cmds.push_back(pack_cmd(ots_pkg::MODE_QUERY, 8'd0, 16'd0));
    pending_cmds.push_back(pack_cmd(ots_pkg::MODE_DELETE, 8'd0, 16'd0));
    pending_cmds.push_back(pack_cmd(MODE_SPARE_7, 8'hFF, 16'hFFFF));        // spare, no table
    pending_cmds.push_back(pack_cmd(ots_pkg::MODE_CREATE, 8'd0, 16'd0));
    pending_cmds.push_back(pack_cmd(ots_pkg::MODE_CREATE, 8'd0, 16'd0));    // exists
    pending_cmds.push_back(pack_cmd(ots_pkg::MODE_RESERVE, 8'd0, 16'd0));   // bad owner
    pending_cmds.push_back(pack_cmd(ots_pkg::MODE_RESERVE, 8'd0, 16'hFFFF));
    pending_cmds.push_back(pack_cmd(ots_pkg::MODE_RESERVE, 8'hFF, 16'h0001));
    pending_cmds.push_back(pack_cmd(ots_pkg::MODE_RESERVE, 8'd0, 16'hAAAA));
    pending_cmds.push_back(pack_cmd(ots_pkg::MODE_RESERVE, 8'd0, 16'd5));   // full
    pending_cmds.push_back(pack_cmd(ots_pkg::MODE_CANCEL, 8'd0, 16'd0));    // owner 0, none free
    pending_cmds.push_back(pack_cmd(ots_pkg::MODE_QUERY, 8'd3, 16'd0));     // just past the end
    pending_cmds.push_back(pack_cmd(ots_pkg::MODE_QUERY, 8'hFF, 16'd0));
    pending_cmds.push_back(pack_cmd(ots_pkg::MODE_QUERY, 8'd0, 16'd0));
    pending_cmds.push_back(pack_cmd(ots_pkg::MODE_RELEASE, 8'd1, 16'd0));
    pending_cmds.push_back(pack_cmd(ots_pkg::MODE_RELEASE, 8'd1, 16'd0));   // already free
    pending_cmds.push_back(pack_cmd(ots_pkg::MODE_RELEASE, 8'hFF, 16'd0));
    pending_cmds.push_back(pack_cmd(ots_pkg::MODE_CANCEL, 8'd0, 16'd0));    // owner 0, one free
    pending_cmds.push_back(pack_cmd(ots_pkg::MODE_CANCEL, 8'd0, 16'h5555)); // not found
    pending_cmds.push_back(pack_cmd(ots_pkg::MODE_RESERVE, 8'd0, 16'hFFFF));
    pending_cmds.push_back(pack_cmd(ots_pkg::MODE_CANCEL, 8'd0, 16'hFFFF)); // frees two slots
    pending_cmds.push_back(pack_cmd(MODE_SPARE_6, 8'h55, 16'h5555));
    pending_cmds.push_back(pack_cmd(ots_pkg::MODE_DELETE, 8'd0, 16'd0));
    pending_cmds.push_back(pack_cmd(ots_pkg::MODE_QUERY, 8'd0, 16'd0));     // gone again

    // random phases; -1 picks a random capacity, 0, 127 and 65 get clamped
    phase_caps = '{1, 0, 2, 127, 64, -1, 65, -1, 9, 64};
    for (int p = 0; p < 10; p++) begin
      wait_drained();
      // first random phase runs with no idling at all
      sender_bursty = (p != 0) && ($urandom_range(0, 3) != 0);
      stall_style   = (p == 0) ? STALL_NONE : stall_style_e'($urandom_range(0, 2));
      cap_setting   = (phase_caps[p] < 0) ? 7'($urandom_range(3, 40)) : 7'(phase_caps[p]);
      write_capacity(cap_setting);
      eff_cap     = (cap_setting == 0) ? 1 :
                    (cap_setting > ots_pkg::SLOTS) ? ots_pkg::SLOTS : cap_setting;
      reserve_pct = $urandom_range(25, 49);
      // rebuild so the new capacity takes effect
      pending_cmds.push_back(pack_cmd(ots_pkg::MODE_DELETE, 8'd0, 16'd0));
      pending_cmds.push_back(pack_cmd(ots_pkg::MODE_CREATE, 8'd0, 16'd0));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        c = random_cmd(eff_cap, reserve_pct);
        pending_cmds.push_back(c);
        // keep tableless stretches short: usually recreate right away
        if (c.mode == ots_pkg::MODE_DELETE && $urandom_range(0, 3) != 0)
          pending_cmds.push_back(pack_cmd(ots_pkg::MODE_CREATE, 8'd0, 16'd0));
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
